[hw/rtl/srsc_pkg.sv]
`default_nettype none

package srsc_pkg;

   localparam int STACK_DEPTH   = 64;
   localparam int POINTER_BYTES = 8;
   localparam int PTR_W         = 64;
   localparam int LEN_W         = 4;
   localparam int ADDR_W        = $clog2(STACK_DEPTH);
   localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
   localparam int ENTRY_W       = 2 * PTR_W;

   localparam logic OP_CALL   = 1'b0;
   localparam logic OP_RETURN = 1'b1;

   typedef enum logic [2:0] {
      STATUS_PUSHED        = 3'd0,
      STATUS_MATCH         = 3'd1,
      STATUS_MATCH_LONGJMP = 3'd2,
      STATUS_EMPTY         = 3'd3,
      STATUS_NOT_FOUND     = 3'd4,
      STATUS_MISMATCH      = 3'd5,
      STATUS_OVERFLOW      = 3'd6
   } srsc_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_CHECK
   } srsc_state_type;

endpackage

`default_nettype wire

[hw/rtl/srsc_ram.sv]
`default_nettype none

module srsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/shadow_return_stack_checker_top.sv]
`default_nettype none

// Shadow return stack checker.
// Input: an item is transferred when start is high and busy is low. A call
// (opcode 0) pushes {stack_pointer - 8, instr_address + call length} when
// not full; a return (opcode 1) pops frames below its stack pointer
// (longjmp unwind), checks the target against the frame of equal pointer.
// Output: exactly one status per item, shown on rsp_status for one cycle
// with rsp_strobe high. The receiver cannot stall the block.
// The status is registered: it appears the cycle after a call or an
// empty-stack return is taken, and the cycle after the last check of a return.
// A call leaves busy low, so another item can be taken straight after it.
// A return first reads the top frame from the single-port-read stack RAM,
// then checks one frame per step, reading the next one while it unwinds.
// busy is high while a return walks the stack.
// Reset clears the entry count; the stack RAM needs no clearing pass,
// since only entries below the count are ever read.
module shadow_return_stack_checker_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_opcode,
   input  wire logic [srsc_pkg::PTR_W-1:0]    req_stack_pointer,
   input  wire logic [srsc_pkg::PTR_W-1:0]    req_instr_address,
   input  wire logic [srsc_pkg::LEN_W-1:0]    req_call_len,
   input  wire logic [srsc_pkg::PTR_W-1:0]    req_target_address,
   output logic                               rsp_strobe,
   output logic [2:0]                         rsp_status
);

   import srsc_pkg::*;

   srsc_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  sp_ff, sp_in;
   logic [PTR_W-1:0]  target_ff, target_in;
   logic              unwound_ff, unwound_in;
   logic              strobe_ff, strobe_in;
   srsc_status_type   status_ff, status_in;

   logic               accept;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [PTR_W-1:0]   entry_sp;
   logic [PTR_W-1:0]   entry_ret;
   logic               entry_above;
   logic               entry_equal;
   logic               last_entry;
   logic               check_done;
   logic [CNT_W-1:0]   count_m1;
   logic [CNT_W-1:0]   count_m2;

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start & ~busy;
   assign entry_sp    = rd_data[ENTRY_W-1:PTR_W];
   assign entry_ret   = rd_data[PTR_W-1:0];
   assign entry_above = entry_sp > sp_ff;
   assign entry_equal = entry_sp == sp_ff;
   assign count_m1    = count_ff - CNT_W'(1);
   assign count_m2    = count_ff - CNT_W'(2);
   assign last_entry  = (count_ff == CNT_W'(1));
   assign check_done  = entry_above | entry_equal | last_entry;

   srsc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_RETURN && count_ff != '0) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (check_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in   = count_ff;
      sp_in      = sp_ff;
      target_in  = target_ff;
      unwound_in = unwound_ff;
      strobe_in  = 1'b0;
      status_in  = status_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[ADDR_W-1:0];
      wr_data    = {req_stack_pointer - PTR_W'(POINTER_BYTES),
                    req_instr_address + PTR_W'(req_call_len)};
      rd_en      = 1'b0;
      rd_addr    = count_m1[ADDR_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            sp_in      = req_stack_pointer;
            target_in  = req_target_address;
            unwound_in = 1'b0;
            if (accept) begin
               if (req_opcode == OP_CALL) begin
                  strobe_in = 1'b1;
                  if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                     status_in = STATUS_OVERFLOW;
                  end else begin
                     wr_en     = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                     status_in = STATUS_PUSHED;
                  end
               end else if (count_ff == '0) begin
                  strobe_in = 1'b1;
                  status_in = STATUS_EMPTY;
               end else begin
                  rd_en = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (entry_above) begin
               strobe_in = 1'b1;
               status_in = STATUS_NOT_FOUND;
            end else begin
               count_in = count_m1;
               if (entry_equal) begin
                  strobe_in = 1'b1;
                  if (entry_ret != target_ff) begin
                     status_in = STATUS_MISMATCH;
                  end else if (unwound_ff) begin
                     status_in = STATUS_MATCH_LONGJMP;
                  end else begin
                     status_in = STATUS_MATCH;
                  end
               end else if (last_entry) begin
                  strobe_in = 1'b1;
                  status_in = STATUS_EMPTY;
               end else begin
                  unwound_in = 1'b1;
                  rd_en      = 1'b1;
                  rd_addr    = count_m2[ADDR_W-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sp_ff      <= sp_in;
      target_ff  <= target_in;
      unwound_ff <= unwound_in;
      status_ff  <= status_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;

endmodule

`default_nettype wire

[bench/tb_shadow_return_stack_checker_top.sv]
`default_nettype none

module tb_shadow_return_stack_checker_top;
   timeunit 1ns;
   timeprecision 1ps;

   import srsc_pkg::*;

   localparam int N_DIRECTED = 25;
   localparam int N_RANDOM   = 512;
   localparam int QUIET_MAX  = 4000;
   localparam int DRAIN_CYC  = 80;

   typedef struct packed {
      logic             op;
      logic [PTR_W-1:0] sp;
      logic [PTR_W-1:0] addr;
      logic [LEN_W-1:0] len;
      logic [PTR_W-1:0] tgt;
   } xfer_type;

   typedef struct packed {
      logic [CNT_W-1:0]                   count;
      logic [STACK_DEPTH-1:0][PTR_W-1:0] sp;
      logic [STACK_DEPTH-1:0][PTR_W-1:0] ra;
   } frame_stack_type;

   typedef struct packed {
      xfer_type        x;
      int              reps;
      bit              known;
      srsc_status_type status;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_opcode = OP_CALL;
   logic [PTR_W-1:0]    req_stack_pointer = '0;
   logic [PTR_W-1:0]    req_instr_address = '0;
   logic [LEN_W-1:0]    req_call_len = '0;
   logic [PTR_W-1:0]    req_target_address = '0;
   logic                rsp_strobe;
   logic [2:0]          rsp_status;

   bit                  row_status_known = 1'b0;
   srsc_status_type     row_status = STATUS_PUSHED;

   frame_stack_type     frames_planned = '0;
   frame_stack_type     frames_seen = '0;
   srsc_status_type     status_due [$];
   srsc_status_type     predicted, want;
   int                  idle_pct = 27;
   int                  burst_left = 0;
   int                  sent = 0;
   int                  checked = 0;
   int                  errors = 0;
   int                  quiet = 0;
   int                  status_seen [8];

   dir_row_type directed_rows [N_DIRECTED] = '{
      '{'{OP_RETURN, 64'h1000, 64'h0, 4'd0, 64'h0}, 1, 1'b1, STATUS_EMPTY},
      '{'{OP_CALL, 64'h1000, 64'h40_0000, 4'd5, 64'h0}, 1, 1'b1, STATUS_PUSHED},
      '{'{OP_RETURN, 64'hFF8, 64'h0, 4'd0, 64'h40_0005}, 1, 1'b1, STATUS_MATCH},
      '{'{OP_CALL, 64'h0, '1, 4'd15, 64'h0}, 1, 1'b1, STATUS_PUSHED},
      '{'{OP_RETURN, '1, 64'h0, 4'd0, 64'hE}, 1, 1'b1, STATUS_EMPTY},
      '{'{OP_CALL, 64'h2000, 64'h100, 4'd0, 64'h0}, 1, 1'b1, STATUS_PUSHED},
      '{'{OP_RETURN, 64'h1000, 64'h0, 4'd0, 64'h0}, 1, 1'b1, STATUS_NOT_FOUND},
      '{'{OP_RETURN, 64'h1FF8, 64'h0, 4'd0, 64'h101}, 1, 1'b1, STATUS_MISMATCH},
      '{'{OP_CALL, 64'h3000, 64'hA000, 4'd3, 64'h0}, 1, 1'b0, STATUS_PUSHED},
      '{'{OP_CALL, 64'h2800, 64'hB000, 4'd7, 64'h0}, 1, 1'b0, STATUS_PUSHED},
      '{'{OP_CALL, 64'h2000, 64'hC000, 4'd2, 64'h0}, 1, 1'b0, STATUS_PUSHED},
      '{'{OP_RETURN, 64'h2FF8, 64'h0, 4'd0, 64'hA003}, 1, 1'b0, STATUS_PUSHED},
      '{'{OP_CALL, 64'h3000, 64'hA000, 4'd3, 64'h0}, 1, 1'b0, STATUS_PUSHED},
      '{'{OP_CALL, 64'h2000, 64'hC000, 4'd2, 64'h0}, 1, 1'b0, STATUS_PUSHED},
      '{'{OP_RETURN, 64'h2FF8, 64'h0, 4'd0, 64'hA004}, 1, 1'b0, STATUS_PUSHED},
      '{'{OP_CALL, 64'h3000, 64'hA000, 4'd3, 64'h0}, 1, 1'b0, STATUS_PUSHED},
      '{'{OP_CALL, 64'h2000, 64'hC000, 4'd2, 64'h0}, 1, 1'b0, STATUS_PUSHED},
      '{'{OP_RETURN, 64'h2800, 64'h0, 4'd0, 64'h0}, 1, 1'b0, STATUS_PUSHED},
      '{'{OP_RETURN, 64'h2FF8, 64'h0, 4'd0, 64'hA003}, 1, 1'b0, STATUS_PUSHED},
      '{'{OP_CALL, 64'h8000, 64'h1234_5678_9ABC_DEF0, 4'd9, 64'h0}, STACK_DEPTH, 1'b1,
        STATUS_PUSHED},
      '{'{OP_CALL, 64'h7000, 64'h0, 4'd1, 64'h0}, 1, 1'b1, STATUS_OVERFLOW},
      '{'{OP_RETURN, '1, '1, 4'd0, 64'h0}, 1, 1'b1, STATUS_EMPTY},
      '{'{OP_CALL, '1, 64'h0, 4'd1, 64'h0}, 1, 1'b1, STATUS_PUSHED},
      '{'{OP_RETURN, 64'hFFFF_FFFF_FFFF_FFF7, 64'h0, 4'd0, '1}, 1, 1'b1, STATUS_MISMATCH},
      '{'{OP_RETURN, 64'h0, '1, 4'd0, '1}, 1, 1'b1, STATUS_EMPTY}
   };

   shadow_return_stack_checker_top uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_stack_pointer  (req_stack_pointer),
      .req_instr_address  (req_instr_address),
      .req_call_len       (req_call_len),
      .req_target_address (req_target_address),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status)
   );

   always #2 clock = ~clock;

   function automatic srsc_status_type predict_status(inout frame_stack_type st,
                                                      input xfer_type x);
      logic             unwound;
      logic [PTR_W-1:0] esp;
      if (x.op == OP_CALL) begin
         if (st.count >= STACK_DEPTH) return STATUS_OVERFLOW;
         st.sp[st.count] = x.sp - 64'(POINTER_BYTES);
         st.ra[st.count] = x.addr + 64'(x.len);
         st.count = st.count + 1'b1;
         return STATUS_PUSHED;
      end
      unwound = 1'b0;
      while (st.count > 0) begin
         esp = st.sp[st.count - 1'b1];
         if (esp > x.sp) return STATUS_NOT_FOUND;
         st.count = st.count - 1'b1;
         if (esp == x.sp) begin
            if (st.ra[st.count] != x.tgt) return STATUS_MISMATCH;
            return unwound ? STATUS_MATCH_LONGJMP : STATUS_MATCH;
         end
         unwound = 1'b1;
      end
      return STATUS_EMPTY;
   endfunction

   // mostly well-formed call/return traffic built on the planned stack
   task automatic build_item(output xfer_type x);
      int roll;
      int n;
      int j;
      roll = $urandom_range(99);
      n = int'(frames_planned.count);
      x.op   = 1'($urandom_range(1));
      x.sp   = {$urandom, $urandom};
      x.addr = {$urandom, $urandom};
      x.len  = LEN_W'($urandom_range(15));
      x.tgt  = {$urandom, $urandom};
      if (burst_left == 0 && roll < 3) burst_left = STACK_DEPTH + $urandom_range(8);
      if (burst_left > 0 || roll < 40) begin
         if (burst_left > 0) burst_left--;
         x.op = OP_CALL;
         if (n > 0) x.sp = frames_planned.sp[n-1] - 64'(8 * $urandom_range(32));
      end else if (roll < 75 && n > 0) begin
         x.op = OP_RETURN;
         x.sp = frames_planned.sp[n-1];
         if ($urandom_range(9) != 0) x.tgt = frames_planned.ra[n-1];
      end else if (roll < 87 && n > 1) begin
         x.op = OP_RETURN;
         j = $urandom_range(n - 2);
         x.sp = frames_planned.sp[j];
         if ($urandom_range(9) != 0) x.tgt = frames_planned.ra[j];
      end else if (roll < 92 && n > 0) begin
         x.op = OP_RETURN;
         x.sp = frames_planned.sp[n-1] - 64'($urandom_range(1, 16));
      end
   endtask

   task automatic drive_item(input xfer_type x, input bit known, input srsc_status_type st);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start              <= 1'b1;
      req_opcode         <= x.op;
      req_stack_pointer  <= x.sp;
      req_instr_address  <= x.addr;
      req_call_len       <= x.len;
      req_target_address <= x.tgt;
      row_status_known   <= known;
      row_status         <= st;
      void'(predict_status(frames_planned, x));
      do @(posedge clock); while (busy);
      sent++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            predicted = predict_status(frames_seen, '{req_opcode, req_stack_pointer,
               req_instr_address, req_call_len, req_target_address});
            status_due.push_back(row_status_known ? row_status : predicted);
         end
         if (rsp_strobe) begin
            status_seen[rsp_status]++;
            if (status_due.size() == 0) begin
               errors++;
               $display("%0t: status %0d with no transfer pending", $time, rsp_status);
            end else begin
               want = status_due.pop_front();
               checked++;
               if (rsp_status !== want) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $time, want, rsp_status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_MAX);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      xfer_type x;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < N_DIRECTED; i++) begin
         for (int r = 0; r < directed_rows[i].reps; r++) begin
            drive_item(directed_rows[i].x, directed_rows[i].known, directed_rows[i].status);
         end
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         idle_pct = (i < N_RANDOM / 3) ? 27 : (i < 2 * N_RANDOM / 3) ? 70 : 0;
         build_item(x);
         drive_item(x, 1'b0, STATUS_PUSHED);
      end
      start <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      $display("run: %0d call/return transfers, %0d statuses checked, %0d errors",
               sent, checked, errors);
      $display("run: pushed %0d match %0d longjmp %0d empty %0d not-found %0d %s %0d %s %0d",
               status_seen[STATUS_PUSHED], status_seen[STATUS_MATCH],
               status_seen[STATUS_MATCH_LONGJMP], status_seen[STATUS_EMPTY],
               status_seen[STATUS_NOT_FOUND], "mismatch", status_seen[STATUS_MISMATCH],
               "overflow", status_seen[STATUS_OVERFLOW]);
      if (errors == 0 && status_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
